>>> rtl/hpp_pkg.sv
// ----------------------------------------------------------------------------
// Homography point projection package
// Widths, register indexes and pipeline types shared by the projection core.
// ----------------------------------------------------------------------------
package hpp_pkg;

    localparam int COORD_W = 24;
    localparam int COEF_W  = 32;
    localparam int PROD_W  = COORD_W + COEF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MAG_W   = SUM_W;
    localparam int FRAC_W  = 8;
    localparam int NUM_W   = MAG_W + FRAC_W + 1;
    localparam int QUOT_W  = COORD_W + 1;
    localparam int WIDE_W  = MAG_W + QUOT_W;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_ROW0_A      = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_B_ROW1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_B      = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW2_A      = 3'd3;
    localparam logic [IDX_W-1:0] REG_H22         = 3'd4;

    localparam logic [COEF_W-1:0] COEF_ONE = 32'h0001_0000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam logic [QUOT_W-1:0] QMAX_POS = 25'h07FFFFF;
    localparam logic [QUOT_W-1:0] QMAX_NEG = 25'h0800000;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [MAG_W-1:0] den;
    } div_meta_t;

endpackage

>>> rtl/homography_point_projection.sv
// ----------------------------------------------------------------------------
// Homography point projection
// Maps Q16.8 points through a 3x3 Q16.16 homography with a perspective divide.
// ----------------------------------------------------------------------------
// Throughput is one point per cycle; the whole pipeline holds while out_stall
// keeps an output beat waiting, so in_stall follows that condition.
// The divider is a chain of 25 restoring stages, one quotient bit each.
// Reset clears all valid bits and loads the identity matrix.
module homography_point_projection
    import hpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_index,
    input  logic [CFG_W-1:0]          wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] proj_x,
    output logic signed [COORD_W-1:0] proj_y,
    output logic                      zero_weight,
    output logic                      clipped
);

    logic [CFG_W-1:0]  row0_a_reg, row0_b_reg, row1_b_reg, row2_a_reg;
    logic [COEF_W-1:0] h22_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_a_reg <= {COEF_ONE, {COEF_W{1'b0}}};
            row0_b_reg <= '0;
            row1_b_reg <= {COEF_ONE, {COEF_W{1'b0}}};
            row2_a_reg <= '0;
            h22_reg    <= COEF_ONE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ROW0_A:      row0_a_reg <= wr_data;
                REG_ROW0_B_ROW1: row0_b_reg <= wr_data;
                REG_ROW1_B:      row1_b_reg <= wr_data;
                REG_ROW2_A:      row2_a_reg <= wr_data;
                REG_H22:         h22_reg    <= wr_data[COEF_W-1:0];
                default:         ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
    assign h00 = row0_a_reg[CFG_W-1:COEF_W];
    assign h01 = row0_a_reg[COEF_W-1:0];
    assign h02 = row0_b_reg[CFG_W-1:COEF_W];
    assign h10 = row0_b_reg[COEF_W-1:0];
    assign h11 = row1_b_reg[CFG_W-1:COEF_W];
    assign h12 = row1_b_reg[COEF_W-1:0];
    assign h20 = row2_a_reg[CFG_W-1:COEF_W];
    assign h21 = row2_a_reg[COEF_W-1:0];
    assign h22 = h22_reg;

    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // Products.
    logic                     a_valid_reg;
    logic signed [PROD_W-1:0] pxa_reg, pxb_reg, pya_reg, pyb_reg, pwa_reg, pwb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (advance)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pxa_reg <= h00 * point_x;
            pxb_reg <= h01 * point_y;
            pya_reg <= h10 * point_x;
            pyb_reg <= h11 * point_y;
            pwa_reg <= h20 * point_x;
            pwb_reg <= h21 * point_y;
        end
    end

    // Sums in units of 2^-24.
    logic                    b_valid_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (advance)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sx_reg <= SUM_W'(pxa_reg) + SUM_W'(pxb_reg)
                      + SUM_W'($signed({h02, {FRAC_W{1'b0}}}));
            sy_reg <= SUM_W'(pya_reg) + SUM_W'(pyb_reg)
                      + SUM_W'($signed({h12, {FRAC_W{1'b0}}}));
            sw_reg <= SUM_W'(pwa_reg) + SUM_W'(pwb_reg)
                      + SUM_W'($signed({h22, {FRAC_W{1'b0}}}));
        end
    end

    // Signs and magnitudes.
    logic             c_valid_reg, c_zero_reg, c_negx_reg, c_negy_reg;
    logic [MAG_W-1:0] c_nx_reg, c_ny_reg, c_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (advance)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_zero_reg <= (sw_reg == '0);
            c_negx_reg <= sx_reg[SUM_W-1] ^ sw_reg[SUM_W-1];
            c_negy_reg <= sy_reg[SUM_W-1] ^ sw_reg[SUM_W-1];
            c_nx_reg   <= sx_reg[SUM_W-1] ? MAG_W'(-sx_reg) : MAG_W'(sx_reg);
            c_ny_reg   <= sy_reg[SUM_W-1] ? MAG_W'(-sy_reg) : MAG_W'(sy_reg);
            c_d_reg    <= sw_reg[SUM_W-1] ? MAG_W'(-sw_reg) : MAG_W'(sw_reg);
        end
    end

    // Scaled and rounded numerators.
    logic             d_valid_reg, d_zero_reg, d_negx_reg, d_negy_reg;
    logic [NUM_W-1:0] d_nx_reg, d_ny_reg;
    logic [MAG_W-1:0] d_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (advance)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_zero_reg <= c_zero_reg;
            d_negx_reg <= c_negx_reg;
            d_negy_reg <= c_negy_reg;
            d_d_reg    <= c_d_reg;
            d_nx_reg   <= NUM_W'({c_nx_reg, {FRAC_W{1'b0}}}) + NUM_W'(c_d_reg >> 1);
            d_ny_reg   <= NUM_W'({c_ny_reg, {FRAC_W{1'b0}}}) + NUM_W'(c_d_reg >> 1);
        end
    end

    // Overflow check and divider chain.
    div_meta_t        meta_reg [0:QUOT_W];
    logic [NUM_W-1:0] remx_reg [0:QUOT_W];
    logic [NUM_W-1:0] remy_reg [0:QUOT_W];
    logic [QUOT_W-1:0] qx_reg  [0:QUOT_W];
    logic [QUOT_W-1:0] qy_reg  [0:QUOT_W];

    div_meta_t meta_head;
    always_comb
    begin
        meta_head.valid = d_valid_reg;
        meta_head.zero  = d_zero_reg;
        meta_head.neg_x = d_negx_reg;
        meta_head.neg_y = d_negy_reg;
        meta_head.ovf_x = MAG_W'(d_nx_reg[NUM_W-1:QUOT_W]) >= d_d_reg;
        meta_head.ovf_y = MAG_W'(d_ny_reg[NUM_W-1:QUOT_W]) >= d_d_reg;
        meta_head.den   = d_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meta_reg[0] <= '0;
        else if (advance)
            meta_reg[0] <= meta_head;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            remx_reg[0] <= d_nx_reg;
            remy_reg[0] <= d_ny_reg;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        localparam int BIT = QUOT_W - 1 - k;
        logic [WIDE_W-1:0] dsh;
        logic              gex, gey;

        assign dsh = WIDE_W'(meta_reg[k].den) << BIT;
        assign gex = WIDE_W'(remx_reg[k]) >= dsh;
        assign gey = WIDE_W'(remy_reg[k]) >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                meta_reg[k+1] <= '0;
            else if (advance)
                meta_reg[k+1] <= meta_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                remx_reg[k+1] <= gex ? remx_reg[k] - dsh[NUM_W-1:0] : remx_reg[k];
                remy_reg[k+1] <= gey ? remy_reg[k] - dsh[NUM_W-1:0] : remy_reg[k];
                qx_reg[k+1]   <= qx_reg[k] | (QUOT_W'(gex) << BIT);
                qy_reg[k+1]   <= qy_reg[k] | (QUOT_W'(gey) << BIT);
            end
        end
    end

    // Sign, saturation and output register.
    div_meta_t                 mt;
    logic [QUOT_W-1:0]         qx, qy;
    logic                      satx, saty;
    logic signed [COORD_W-1:0] px_next, py_next;

    assign mt = meta_reg[QUOT_W];
    assign qx = qx_reg[QUOT_W];
    assign qy = qy_reg[QUOT_W];

    always_comb
    begin
        satx = mt.ovf_x || (mt.neg_x ? (qx > QMAX_NEG) : (qx > QMAX_POS));
        saty = mt.ovf_y || (mt.neg_y ? (qy > QMAX_NEG) : (qy > QMAX_POS));
        if (satx)
            px_next = mt.neg_x ? COORD_MIN : COORD_MAX;
        else
            px_next = mt.neg_x ? COORD_W'(-qx) : COORD_W'(qx);
        if (saty)
            py_next = mt.neg_y ? COORD_MIN : COORD_MAX;
        else
            py_next = mt.neg_y ? COORD_W'(-qy) : COORD_W'(qy);
    end

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] proj_x_reg, proj_y_reg;
    logic                      zero_reg, clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= mt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            proj_x_reg <= mt.zero ? '0 : px_next;
            proj_y_reg <= mt.zero ? '0 : py_next;
            zero_reg   <= mt.zero;
            clip_reg   <= !mt.zero && (satx || saty);
        end
    end

    assign out_valid   = out_valid_reg;
    assign proj_x      = proj_x_reg;
    assign proj_y      = proj_y_reg;
    assign zero_weight = zero_reg;
    assign clipped     = clip_reg;

`ifndef SYNTHESIS
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_weight |-> proj_x == '0 && proj_y == '0 && !clipped)
        else $error("zero weight beat carries nonzero fields");

    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> proj_x == COORD_MAX || proj_x == COORD_MIN
                                 || proj_y == COORD_MAX || proj_y == COORD_MIN)
        else $error("clipped beat without a saturated coordinate");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall out of step with output stall");
`endif

endmodule

>>> verif/homography_point_projection_tb.sv
// ----------------------------------------------------------------------------
// Homography point projection testbench
// Streams Q16.8 points through the projection core under several matrices,
// predicts each projected point in fixed point and compares every output beat.
// ----------------------------------------------------------------------------
module homography_point_projection_tb
    import hpp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
    localparam logic [IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      zw;
        logic                      clip;
    } proj_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      wr_en = 1'b0;
    logic [IDX_W-1:0]          wr_index = '0;
    logic [CFG_W-1:0]          wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic                      zero_weight;
    logic                      clipped;

    logic signed [COEF_W-1:0] h [9];
    point_t pending_points[$];
    proj_t  expected_projs[$];
    int     errors = 0;
    int     cycles = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     hold_cycles = 0;
    int     sent_total = 0;
    int     checked_total = 0;
    logic   feeding = 1'b0;

    homography_point_projection u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [COORD_W-1:0] divide_q8(
        input logic signed [63:0] num, input logic signed [63:0] den, inout logic clip);
        logic        neg;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n * 64'd256 + d / 2) / d;
        if (!neg)
        begin
            if (q > 64'd8388607)
            begin
                q = 64'd8388607;
                clip = 1'b1;
            end
            return q[COORD_W-1:0];
        end
        if (q > 64'd8388608)
        begin
            q = 64'd8388608;
            clip = 1'b1;
        end
        q = -q;
        return q[COORD_W-1:0];
    endfunction

    function automatic proj_t project_point(input point_t p);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic signed [63:0] sw;
        proj_t r;
        x = p.px;
        y = p.py;
        sx = h[0] * x + h[1] * y + h[2] * 64'sd256;
        sy = h[3] * x + h[4] * y + h[5] * 64'sd256;
        sw = h[6] * x + h[7] * y + h[8] * 64'sd256;
        r = '0;
        if (sw == 0)
        begin
            r.zw = 1'b1;
            return r;
        end
        r.px = divide_q8(sx, sw, r.clip);
        r.py = divide_q8(sy, sw, r.clip);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic queue_point(input point_t p);
        pending_points = {pending_points, p};
        sent_total++;
    endtask

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_ROW0_A:      begin h[0] = val[63:32]; h[1] = val[31:0]; end
            REG_ROW0_B_ROW1: begin h[2] = val[63:32]; h[3] = val[31:0]; end
            REG_ROW1_B:      begin h[4] = val[63:32]; h[5] = val[31:0]; end
            REG_ROW2_A:      begin h[6] = val[63:32]; h[7] = val[31:0]; end
            REG_H22:         h[8] = val[31:0];
            default:         ;
        endcase
    endtask

    task automatic load_matrix(input logic signed [COEF_W-1:0] m [9]);
        write_coef(REG_ROW0_A, {m[0], m[1]});
        write_coef(REG_ROW0_B_ROW1, {m[2], m[3]});
        write_coef(REG_ROW1_B, {m[4], m[5]});
        write_coef(REG_ROW2_A, {m[6], m[7]});
        write_coef(REG_H22, {$urandom, m[8]});
    endtask

    task automatic run_phase(input int n, input int mode);
        point_t p;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: begin
                    p.px = COORD_W'($urandom);
                    p.py = COORD_W'($urandom);
                end
                1: begin
                    p.px = COORD_W'($signed($urandom_range(0, 8191)) - 4096);
                    p.py = COORD_W'($signed($urandom_range(0, 8191)) - 4096);
                end
                default: begin
                    p.px = ($urandom_range(0, 1)) ? COORD_MAX : COORD_MIN;
                    p.py = ($urandom_range(0, 2) == 0) ? COORD_MIN : COORD_W'($urandom);
                end
            endcase
            queue_point(p);
        end
        while (checked_total < sent_total)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_matrix(input int kind);
        logic signed [COEF_W-1:0] m [9];
        for (int i = 0; i < 9; i++)
            m[i] = (kind == 0) ? $urandom
                 : $signed($urandom_range(0, 262143)) - 131072;
        if (kind == 1)
        begin
            m[6] = $signed($urandom_range(0, 255)) - 128;
            m[7] = $signed($urandom_range(0, 255)) - 128;
            m[8] = 32'sh0001_0000 + $signed($urandom_range(0, 65535)) - 32768;
        end
        load_matrix(m);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sender: holds a beat until taken, then offers the next or idles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                    expected_projs = {expected_projs, project_point({point_x, point_y})};
                if (feeding && pending_points.size() != 0
                    && $urandom_range(0, 99) >= send_idle)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    in_valid <= 1'b1;
                    point_x <= p.px;
                    point_y <= p.py;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_projs.size() == 0)
                    report_mismatch("unexpected beat", proj_x, 0);
                else
                begin
                    proj_t e;
                    e = expected_projs.pop_front();
                    checked_total++;
                    if (proj_x !== e.px) report_mismatch("proj_x", proj_x, e.px);
                    if (proj_y !== e.py) report_mismatch("proj_y", proj_y, e.py);
                    if (zero_weight !== e.zw)
                        report_mismatch("zero_weight", zero_weight, e.zw);
                    if (clipped !== e.clip) report_mismatch("clipped", clipped, e.clip);
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    initial
    begin
        logic signed [COEF_W-1:0] m [9];
        point_t p;
        h = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        feeding <= 1'b1;

        // Identity at reset: extremes pass through unchanged.
        p = '{COORD_MAX, COORD_MIN}; queue_point(p);
        p = '{COORD_MIN, COORD_MAX}; queue_point(p);
        p = '{24'sh0, 24'sh0};       queue_point(p);
        p = '{24'sh000100, -24'sh000100}; queue_point(p);
        run_phase(0, 0);

        // Zero weight and saturation both ways.
        m = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
              32'sh7FFFFFFF, 32'sh80000000, 0, 0, 1};
        load_matrix(m);
        run_phase(6, 2);
        m = '{32'sh8000, 0, 0, 0, 32'sh8000, 0, 32'sh10000, 0, 0};
        load_matrix(m);
        p = '{24'sh0, 24'sh000005};  queue_point(p);
        p = '{24'sh000003, 24'sh1};  queue_point(p);
        p = '{-24'sh000003, 24'sh1}; queue_point(p);
        p = '{COORD_MIN, COORD_MAX}; queue_point(p);
        run_phase(0, 0);
        write_coef(IDX_UNUSED_HI, '1);
        write_coef(IDX_UNUSED_LO, '1);

        send_idle = 23;
        recv_idle = 84;
        random_matrix(1);
        run_phase(200, 1);
        random_matrix(0);
        run_phase(200, 0);

        send_idle = 84;
        recv_idle = 23;
        random_matrix(1);
        run_phase(300, 1);
        random_matrix(0);
        run_phase(150, 2);

        send_idle = 0;
        recv_idle = 0;
        random_matrix(1);
        hold_cycles = 120;
        run_phase(500, 1);
        random_matrix(0);
        run_phase(450, 0);

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
